@@ hdl/qpr_pkg.sv @@
`default_nettype none
package qpr_pkg;

  localparam int unsigned QW       = 16;   // rotor part width, Q1.14
  localparam int unsigned REG_IDX_W = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ANGLE  = 2'd0,
    REG_AXIS_X = 2'd1,
    REG_AXIS_Y = 2'd2,
    REG_AXIS_Z = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    RS_IDLE  = 2'd0,
    RS_ITER  = 2'd1,
    RS_SCALE = 2'd2,
    RS_DONE  = 2'd3
  } rstate_t;

  typedef logic signed [QW-1:0] rotor_part_t;

  typedef struct packed {
    rotor_part_t a;
    rotor_part_t x;
    rotor_part_t y;
    rotor_part_t z;
  } rotor_t;

  // Arctangent of 2^-i, 2^32 per turn.
  function automatic logic signed [33:0] atan_turns(input logic [4:0] i);
    logic signed [33:0] r;
    begin
      unique case (i)
        5'd0:  r = 34'sd536870912;
        5'd1:  r = 34'sd316933406;
        5'd2:  r = 34'sd167458907;
        5'd3:  r = 34'sd85004756;
        5'd4:  r = 34'sd42667331;
        5'd5:  r = 34'sd21354465;
        5'd6:  r = 34'sd10679838;
        5'd7:  r = 34'sd5340245;
        5'd8:  r = 34'sd2670163;
        5'd9:  r = 34'sd1335087;
        5'd10: r = 34'sd667544;
        5'd11: r = 34'sd333772;
        5'd12: r = 34'sd166886;
        5'd13: r = 34'sd83443;
        5'd14: r = 34'sd41722;
        5'd15: r = 34'sd20861;
        5'd16: r = 34'sd10430;
        5'd17: r = 34'sd5215;
        5'd18: r = 34'sd2608;
        5'd19: r = 34'sd1304;
        5'd20: r = 34'sd652;
        5'd21: r = 34'sd326;
        5'd22: r = 34'sd163;
        5'd23: r = 34'sd81;
        default: r = 34'sd0;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

@@ hdl/qpr_rotor.sv @@
`default_nettype none
// Builds q from angle and axis: one CORDIC step per cycle, then a scale pass.
module qpr_rotor #(
  parameter int unsigned CORDIC_STEPS = 14
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [15:0]     angle,
  input  wire logic [15:0]     axis_x,
  input  wire logic [15:0]     axis_y,
  input  wire logic [15:0]     axis_z,
  output logic                 busy,
  output logic                 done,
  output qpr_pkg::rotor_t      rotor
);
  import qpr_pkg::*;

  localparam int unsigned SW = $clog2(CORDIC_STEPS + 4);

  rstate_t state, state_next;
  logic [SW-1:0] step;
  logic [1:0] part;
  logic signed [33:0] cx, cy, cz;
  logic neg;
  logic signed [33:0] cx_next, cy_next, cz_next;
  logic signed [33:0] dx, dy;
  logic signed [31:0] z0;
  logic signed [33:0] sin_v;
  logic signed [49:0] prod;
  logic signed [49:0] prod_r;
  logic signed [15:0] axis_sel;
  logic signed [34:0] cos_r;

  always_comb begin
    state_next = state;
    unique case (state)
      RS_IDLE:  if (start) state_next = RS_ITER;
      RS_ITER:  if (step == SW'(CORDIC_STEPS - 1)) state_next = RS_SCALE;
      RS_SCALE: if (part == 2'd3) state_next = RS_DONE;
      RS_DONE:  state_next = start ? RS_ITER : RS_DONE;
      default:  state_next = RS_IDLE;
    endcase
  end

  always_comb begin
    busy = (state == RS_ITER) || (state == RS_SCALE);
    done = (state == RS_DONE);
  end

  always_comb begin
    dx = cy >>> step;
    dy = cx >>> step;
    if (!cz[33]) begin
      cx_next = cx - dx;
      cy_next = cy + dy;
      cz_next = cz - atan_turns(5'(step));
    end else begin
      cx_next = cx + dx;
      cy_next = cy - dy;
      cz_next = cz + atan_turns(5'(step));
    end
  end

  assign z0 = signed'({1'b0, angle, 15'd0});
  assign sin_v = neg ? -cy : cy;
  always_comb begin
    unique case (part)
      2'd0: axis_sel = signed'(axis_x);
      2'd1: axis_sel = signed'(axis_y);
      default: axis_sel = signed'(axis_z);
    endcase
  end
  assign prod = sin_v * axis_sel;
  assign prod_r = (prod + 50'sd536870912) >>> 30;
  assign cos_r = ((neg ? -35'(cx) : 35'(cx)) + 35'sd32768) >>> 16;

  function automatic rotor_part_t sat16(input logic signed [49:0] v);
    if (v > 50'sd32767) return 16'sh7fff;
    else if (v < -50'sd32768) return 16'sh8000;
    else return v[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RS_IDLE;
      step  <= '0;
      part  <= '0;
    end else begin
      state <= state_next;
      if (state_next == RS_ITER && state != RS_ITER) begin
        step <= '0;
        // Fold phases beyond a quarter turn by a half turn.
        if (z0 > 32'sd1073741824) begin
          cz <= 34'(z0) - 34'sd2147483648; neg <= 1'b1;
        end else if (z0 < -32'sd1073741824) begin
          cz <= 34'(z0) + 34'sd2147483648; neg <= 1'b1;
        end else begin
          cz <= 34'(z0); neg <= 1'b0;
        end
        cx <= 34'sd652032874;
        cy <= '0;
      end else if (state == RS_ITER) begin
        cx <= cx_next; cy <= cy_next; cz <= cz_next;
        step <= step + 1'b1;
        part <= '0;
      end else if (state == RS_SCALE) begin
        part <= part + 1'b1;
        unique case (part)
          2'd0: begin
            rotor.x <= sat16(prod_r);
            rotor.a <= sat16(50'(cos_r));
          end
          2'd1: rotor.y <= sat16(prod_r);
          default: rotor.z <= sat16(prod_r);
        endcase
      end
    end
  end
endmodule
`default_nettype wire

@@ hdl/qpr_pipe.sv @@
`default_nettype none
// Five-stage rotation datapath with a global enable.
module qpr_pipe #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   en,
  input  wire logic                   in_valid,
  input  wire logic [COORD_WIDTH-1:0] px,
  input  wire logic [COORD_WIDTH-1:0] py,
  input  wire logic [COORD_WIDTH-1:0] pz,
  input  qpr_pkg::rotor_t             q,
  output logic                        out_valid,
  output logic [COORD_WIDTH-1:0]      rx,
  output logic [COORD_WIDTH-1:0]      ry,
  output logic [COORD_WIDTH-1:0]      rz
);
  import qpr_pkg::*;

  localparam int unsigned TDROP = (COORD_WIDTH > 16) ? COORD_WIDTH - 16 : 0;
  localparam int unsigned PW = COORD_WIDTH + QW;      // one product
  localparam int unsigned TW = PW + 2 - TDROP;        // t after drop
  localparam int unsigned RPW = TW + QW;              // second product
  localparam int unsigned RW = RPW + 2;
  localparam int unsigned FS = 28 - TDROP;

  logic [4:0] v;
  logic signed [PW-1:0] m1 [12];
  logic signed [TW-1:0] t [4];
  logic signed [RPW-1:0] m2 [12];
  logic signed [RW-1:0] r [3];
  logic signed [COORD_WIDTH-1:0] pa [3];
  logic signed [QW-1:0] qa [4];

  assign pa[0] = signed'(px);
  assign pa[1] = signed'(py);
  assign pa[2] = signed'(pz);
  assign qa[0] = q.a; assign qa[1] = q.x; assign qa[2] = q.y; assign qa[3] = q.z;

  function automatic logic signed [TW-1:0] drop(input logic signed [PW+1:0] s);
    logic signed [PW+2:0] w;
    w = 0;
    if (TDROP == 0) return TW'(s);
    w = (PW+3)'(s) + ((PW+3)'(1) <<< (TDROP - 1));
    return TW'(w >>> TDROP);
  endfunction

  function automatic logic [COORD_WIDTH-1:0] fin(input logic signed [RW-1:0] s);
    logic signed [RW:0] w;
    logic signed [RW:0] hi;
    w  = ((RW+1)'(s) + ((RW+1)'(1) <<< (FS - 1))) >>> FS;
    hi = ((RW+1)'(1) <<< (COORD_WIDTH - 1)) - 1;
    if (w > hi) return {1'b0, {(COORD_WIDTH-1){1'b1}}};
    else if (w < -hi - 1) return {1'b1, {(COORD_WIDTH-1){1'b0}}};
    else return w[COORD_WIDTH-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else if (en) v <= {v[3:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: p * conj(q) products
      m1[0]  <= pa[0] * qa[1]; m1[1]  <= pa[1] * qa[2]; m1[2]  <= pa[2] * qa[3];
      m1[3]  <= pa[0] * qa[0]; m1[4]  <= pa[1] * qa[3]; m1[5]  <= pa[2] * qa[2];
      m1[6]  <= pa[0] * qa[3]; m1[7]  <= pa[1] * qa[0]; m1[8]  <= pa[2] * qa[1];
      m1[9]  <= pa[0] * qa[2]; m1[10] <= pa[1] * qa[1]; m1[11] <= pa[2] * qa[0];
      // stage 2: sums
      t[0] <= drop((PW+2)'(m1[0]) + (PW+2)'(m1[1]) + (PW+2)'(m1[2]));
      t[1] <= drop((PW+2)'(m1[3]) - (PW+2)'(m1[4]) + (PW+2)'(m1[5]));
      t[2] <= drop((PW+2)'(m1[6]) + (PW+2)'(m1[7]) - (PW+2)'(m1[8]));
      t[3] <= drop(-(PW+2)'(m1[9]) + (PW+2)'(m1[10]) + (PW+2)'(m1[11]));
      // stage 3: q * t products
      m2[0]  <= qa[0] * t[1]; m2[1]  <= qa[1] * t[0]; m2[2]  <= qa[2] * t[3];
      m2[3]  <= qa[3] * t[2];
      m2[4]  <= qa[0] * t[2]; m2[5]  <= qa[1] * t[3]; m2[6]  <= qa[2] * t[0];
      m2[7]  <= qa[3] * t[1];
      m2[8]  <= qa[0] * t[3]; m2[9]  <= qa[1] * t[2]; m2[10] <= qa[2] * t[1];
      m2[11] <= qa[3] * t[0];
      // stage 4: sums
      r[0] <= RW'(m2[0]) + RW'(m2[1]) + RW'(m2[2]) - RW'(m2[3]);
      r[1] <= RW'(m2[4]) - RW'(m2[5]) + RW'(m2[6]) + RW'(m2[7]);
      r[2] <= RW'(m2[8]) + RW'(m2[9]) - RW'(m2[10]) + RW'(m2[11]);
      // stage 5: round and saturate
      rx <= fin(r[0]); ry <= fin(r[1]); rz <= fin(r[2]);
    end
  end

  assign out_valid = v[4];

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v)) else $error("pipe valid moved while stalled");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (!en && out_valid) |=> $stable(rx) && $stable(ry) && $stable(rz))
    else $error("pipe output changed while stalled");
  a_shift: assert property (@(posedge clk) disable iff (rst)
    en |=> v[1] == $past(v[0])) else $error("pipe valid lost");
endmodule
`default_nettype wire

@@ hdl/quaternion_point_rotation.sv @@
`default_nettype none
// channel   | direction | handshake            | payload
// s_axis    | in        | tvalid/tready        | tdata: point_x, point_y, point_z
// m_axis    | out       | tvalid/tready        | tdata: rotated_x, rotated_y, rotated_z
// cfg       | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data (16 bits used)
// One point per cycle while s_axis_tready is high.
// After reset or a lone register write, s_axis_tready stays low while the
// rotor is rebuilt; a write during a rebuild forces another full pass.
// Reset is synchronous; the whole pipeline advances together and halts when
// a valid result is not taken, so a stall loses nothing.
module quaternion_point_rotation #(
  parameter int unsigned CORDIC_STEPS = 14,
  parameter int unsigned COORD_WIDTH  = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata, // point_x, point_y, point_z
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata, // rotated_x, rotated_y, rotated_z
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [15:0]                cfg_data
);
  import qpr_pkg::*;

  localparam int unsigned DW = ((3*COORD_WIDTH+7)/8)*8;

  logic [15:0] angle, axis_x, axis_y, axis_z;
  logic rotor_ready;
  logic rot_pending;
  logic rot_busy, rot_done, rot_start;
  rotor_t rotor;
  logic en, take;
  logic [COORD_WIDTH-1:0] rx, ry, rz;

  assign cfg_ready = 1'b1;
  assign rot_start = rot_pending && !rot_busy;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && rotor_ready;
  assign take = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle <= '0; axis_x <= '0; axis_y <= '0; axis_z <= 16'd16384;
      rotor_ready <= 1'b0;
      rot_pending <= 1'b1;
    end else begin
      if (cfg_valid) begin
        unique case (reg_idx_t'(cfg_index))
          REG_ANGLE:  angle  <= cfg_data;
          REG_AXIS_X: axis_x <= cfg_data;
          REG_AXIS_Y: axis_y <= cfg_data;
          REG_AXIS_Z: axis_z <= cfg_data;
          default: ;
        endcase
        rotor_ready <= 1'b0;
        rot_pending <= 1'b1;
      end else begin
        if (rot_start) rot_pending <= 1'b0;
        // Mark ready only for a build that started after the last write.
        if (!rot_pending && rot_done) rotor_ready <= 1'b1;
      end
    end
  end

  qpr_rotor #(.CORDIC_STEPS(CORDIC_STEPS)) u_rotor (
    .clk, .rst, .start(rot_start), .angle, .axis_x, .axis_y, .axis_z,
    .busy(rot_busy), .done(rot_done), .rotor
  );

  qpr_pipe #(.COORD_WIDTH(COORD_WIDTH)) u_pipe (
    .clk, .rst, .en, .in_valid(take),
    .px(s_axis_tdata[COORD_WIDTH-1:0]),
    .py(s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .pz(s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
    .q(rotor), .out_valid(m_axis_tvalid), .rx, .ry, .rz
  );

  assign m_axis_tdata = DW'({rz, ry, rx});

  a_no_take_unready: assert property (@(posedge clk) disable iff (rst)
    take |-> rotor_ready) else $error("point taken before rotor built");
  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |=> !rotor_ready) else $error("rotor still marked ready");
  a_ready_quiet: assert property (@(posedge clk) disable iff (rst)
    rotor_ready |-> !rot_busy) else $error("rotor busy while ready");
endmodule
`default_nettype wire
